/* design/gtpw_pkg.sv */
// ----------------------------------------------------------------------------
// gtpw_pkg: shared types and constants of the glyph text pixel writer
// Field widths, the sequencer state type, the 5x7 font and the character
// to font slot mapping.
// ----------------------------------------------------------------------------
package gtpw_pkg;

    localparam int unsigned CODE_W    = 8;
    localparam int unsigned POS_W     = 12;
    localparam int unsigned COLOR_W   = 16;
    localparam int unsigned ADDR_W    = 20;
    localparam int unsigned COORD_W   = 10;
    localparam int unsigned WIDTH_W   = 11;
    localparam int unsigned HEIGHT_W  = 10;
    localparam int unsigned CURSOR_W  = 13;
    localparam int unsigned CFG_IDX_W = 1;

    localparam int unsigned GLYPH_ROWS    = 7;
    localparam int unsigned GLYPH_COLS    = 5;
    localparam int unsigned GLYPH_CELLS   = GLYPH_ROWS * GLYPH_COLS;
    localparam int unsigned GLYPH_SLOTS   = 39;
    localparam int unsigned GLYPH_ADVANCE = 6;
    localparam int unsigned SLOT_W        = 6;
    localparam int unsigned ROW_W         = 3;
    localparam int unsigned CELL_IDX_W    = 6;

    localparam logic [SLOT_W-1:0] DIGIT_BASE = 6'd26;
    localparam logic [SLOT_W-1:0] SPACE_SLOT = 6'd36;
    localparam logic [SLOT_W-1:0] COLON_SLOT = 6'd37;
    localparam logic [SLOT_W-1:0] COMMA_SLOT = 6'd38;
    localparam logic [SLOT_W-1:0] NO_GLYPH   = 6'd63;

    localparam logic [CODE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CODE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CODE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CODE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CODE_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CODE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CODE_W-1:0] CHAR_COLON   = 8'h3A;
    localparam logic [CODE_W-1:0] CHAR_COMMA   = 8'h2C;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd320;
    localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 10'd240;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_write;
    } t_pixel;

    // Each row holds five columns, leftmost column in bit 4.
    localparam logic [4:0] FONT_ROM [GLYPH_SLOTS][GLYPH_ROWS] = '{
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C},
        '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
        '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        '{5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h04, 5'h00, 5'h04, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08}
    };

    // Letters fold onto one set of slots; unknown codes get no glyph.
    function automatic logic [SLOT_W-1:0] glyph_slot(input logic [CODE_W-1:0] code);
        logic [SLOT_W-1:0] slot;
        slot = NO_GLYPH;
        if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
            slot = SLOT_W'(code - CHAR_UPPER_A);
        end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
            slot = SLOT_W'(code - CHAR_LOWER_A);
        end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            slot = DIGIT_BASE + SLOT_W'(code - CHAR_ZERO);
        end else if (code == CHAR_SPACE) begin
            slot = SPACE_SLOT;
        end else if (code == CHAR_COLON) begin
            slot = COLON_SLOT;
        end else if (code == CHAR_COMMA) begin
            slot = COMMA_SLOT;
        end
        return slot;
    endfunction

endpackage

/* design/gtpw_if.sv */
// ----------------------------------------------------------------------------
// gtpw interfaces: request channels of the glyph text pixel writer
// Character requests in, pixel write requests out, and register writes.
// ----------------------------------------------------------------------------
interface gtpw_char_if import gtpw_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CODE_W-1:0]         char_code;
    logic                      starts_text;
    logic signed [POS_W-1:0]   start_x;
    logic signed [POS_W-1:0]   start_y;
    logic [COLOR_W-1:0]        ink_color;

    modport source (output valid, char_code, starts_text, start_x, start_y, ink_color,
                    input ready);
    modport sink (input valid, char_code, starts_text, start_x, start_y, ink_color,
                  output ready);
endinterface

interface gtpw_pixel_if import gtpw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   pixel_address;
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [COLOR_W-1:0]  pixel_color;
    logic                last_write;

    modport source (output valid, pixel_address, pixel_x, pixel_y, pixel_color, last_write,
                    input ready);
    modport sink (input valid, pixel_address, pixel_x, pixel_y, pixel_color, last_write,
                  output ready);
endinterface

interface gtpw_cfg_if import gtpw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [WIDTH_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/gtpw_glyph_mask.sv */
// ----------------------------------------------------------------------------
// gtpw_glyph_mask: visible lit cells of one glyph
// Looks up the glyph rows and clips every cell against the frame, giving
// one bit per cell in row-major order.
// ----------------------------------------------------------------------------
module gtpw_glyph_mask import gtpw_pkg::*; (
    input  logic [SLOT_W-1:0]          i_slot,
    input  logic signed [CURSOR_W-1:0] i_cursor,
    input  logic signed [POS_W-1:0]    i_top,
    input  logic [WIDTH_W-1:0]         i_width,
    input  logic [HEIGHT_W-1:0]        i_height,
    output logic [GLYPH_CELLS-1:0]     o_mask
);

    logic [4:0]            rows [GLYPH_ROWS];
    logic [GLYPH_ROWS-1:0] row_vis;
    logic [GLYPH_COLS-1:0] col_vis;
    logic signed [CURSOR_W-1:0] py [GLYPH_ROWS];
    logic signed [CURSOR_W-1:0] px [GLYPH_COLS];

    always_comb begin
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            rows[r] = (i_slot < SLOT_W'(GLYPH_SLOTS)) ? FONT_ROM[i_slot][r] : 5'h00;
            py[r] = $signed({i_top[POS_W-1], i_top}) + $signed(CURSOR_W'(r));
            row_vis[r] = (py[r] >= 0)
                       && (py[r] < $signed({{(CURSOR_W-HEIGHT_W){1'b0}}, i_height}));
        end
        for (int c = 0; c < GLYPH_COLS; c++) begin
            px[c] = i_cursor + $signed(CURSOR_W'(c));
            col_vis[c] = (px[c] >= 0)
                       && (px[c] < $signed({{(CURSOR_W-WIDTH_W){1'b0}}, i_width}));
        end
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            for (int c = 0; c < GLYPH_COLS; c++) begin
                o_mask[r*GLYPH_COLS + c] = rows[r][GLYPH_COLS-1-c] & row_vis[r] & col_vis[c];
            end
        end
    end

endmodule

/* design/glyph_text_pixel_writer_top.sv */
// ----------------------------------------------------------------------------
// glyph_text_pixel_writer_top: 5x7 font text renderer producing pixel writes
// Draws one character per request and emits one pixel write request for
// every lit glyph pixel that lies inside the configured frame.
// ----------------------------------------------------------------------------
// The block takes one character request at a time and is not ready while it
// draws. A request with starts_text set loads the start column and top row
// and restarts a stopped string. A character whose glyph would reach the
// right edge stops the string, and later characters are dropped until the
// next start. Dropped characters are taken without drawing. A drawn
// character is accepted in the idle state, builds its clipped glyph mask
// and the row base address (the only multiply) in the setup state, and
// then scans the glyph cells up to and including its last visible lit
// pixel, waiting while the pixel sink holds ready low. The scan walks the
// 35 cells in row-major order. A character without glyph, or with no
// visible pixel, returns to idle from the setup state. last_write marks
// the final pixel request of a character. Registers must be written only
// while the block is idle; the block itself does not enforce it. The
// register port is always ready.
// ----------------------------------------------------------------------------
module glyph_text_pixel_writer_top import gtpw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gtpw_char_if.sink     i_char,
    gtpw_pixel_if.source  o_pixel,
    gtpw_cfg_if.sink      i_cfg
);

    t_state                     r_state, n_state;
    logic [WIDTH_W-1:0]         r_width;
    logic [HEIGHT_W-1:0]        r_height;
    logic signed [CURSOR_W-1:0] r_cursor, n_cursor;
    logic signed [POS_W-1:0]    r_top, n_top;
    logic                       r_stopped, n_stopped;
    logic [SLOT_W-1:0]          r_slot, n_slot;
    logic [COLOR_W-1:0]         r_ink, n_ink;
    logic [GLYPH_CELLS-1:0]     r_mask, n_mask;
    logic [CELL_IDX_W-1:0]      r_pos, n_pos;
    logic [ROW_W-1:0]           r_row, n_row;
    logic [ROW_W-1:0]           r_col, n_col;
    logic [ADDR_W-1:0]          r_base, n_base;
    t_pixel                     r_out, n_out;
    logic                       r_out_valid, n_out_valid;

    logic [GLYPH_CELLS-1:0]     glyph_mask;
    logic signed [23:0]         row0_prod;
    logic signed [CURSOR_W-1:0] eff_cursor, cur_px, cur_py;
    logic signed [POS_W-1:0]    eff_top;
    logic                       eff_stopped;
    logic                       glyph_fits;
    logic                       char_accept;
    logic                       out_free;
    logic                       cell_lit;
    logic [GLYPH_CELLS-1:0]     mask_left;

    gtpw_glyph_mask u_mask (
        .i_slot   (r_slot),
        .i_cursor (r_cursor),
        .i_top    (r_top),
        .i_width  (r_width),
        .i_height (r_height),
        .o_mask   (glyph_mask)
    );

    assign i_char.ready = (r_state == ST_IDLE);
    assign char_accept  = i_char.valid && i_char.ready;
    assign i_cfg.ready  = 1'b1;

    assign o_pixel.valid         = r_out_valid;
    assign o_pixel.pixel_address = r_out.pixel_address;
    assign o_pixel.pixel_x       = r_out.pixel_x;
    assign o_pixel.pixel_y       = r_out.pixel_y;
    assign o_pixel.pixel_color   = r_out.pixel_color;
    assign o_pixel.last_write    = r_out.last_write;

    // A start request overrides the saved cursor, top row and stop flag.
    assign eff_cursor  = i_char.starts_text ? $signed({i_char.start_x[POS_W-1], i_char.start_x})
                                            : r_cursor;
    assign eff_top     = i_char.starts_text ? i_char.start_y : r_top;
    assign eff_stopped = i_char.starts_text ? 1'b0 : r_stopped;
    assign glyph_fits  = (eff_cursor + 13'sd5)
                       < $signed({{(CURSOR_W-WIDTH_W){1'b0}}, r_width});

    // Address of column zero of the glyph's first row, modulo the field width.
    assign row0_prod = $signed(r_top) * $signed({1'b0, r_width});

    assign cur_px    = r_cursor + $signed({{(CURSOR_W-ROW_W){1'b0}}, r_col});
    assign cur_py    = $signed({r_top[POS_W-1], r_top})
                     + $signed({{(CURSOR_W-ROW_W){1'b0}}, r_row});
    assign out_free  = !r_out_valid || o_pixel.ready;
    assign cell_lit  = r_mask[r_pos];
    assign mask_left = r_mask & ~(GLYPH_CELLS'(1) << r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= IMAGE_WIDTH_RST;
            r_height    <= IMAGE_HEIGHT_RST;
            r_cursor    <= '0;
            r_top       <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_top       <= n_top;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg.data;
                    REG_IMAGE_HEIGHT: r_height <= i_cfg.data[HEIGHT_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_ink  <= n_ink;
        r_mask <= n_mask;
        r_pos  <= n_pos;
        r_row  <= n_row;
        r_col  <= n_col;
        r_base <= n_base;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_top       = r_top;
        n_stopped   = r_stopped;
        n_slot      = r_slot;
        n_ink       = r_ink;
        n_mask      = r_mask;
        n_pos       = r_pos;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_pixel.ready;

        unique case (r_state)
            ST_IDLE: begin
                if (char_accept) begin
                    n_cursor  = eff_cursor;
                    n_top     = eff_top;
                    n_stopped = eff_stopped;
                    if (!eff_stopped) begin
                        if (!glyph_fits) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_slot  = glyph_slot(i_char.char_code);
                            n_ink   = i_char.ink_color;
                            n_state = ST_SETUP;
                        end
                    end
                end
            end
            ST_SETUP: begin
                n_mask = glyph_mask;
                n_base = row0_prod[ADDR_W-1:0];
                n_pos  = '0;
                n_row  = '0;
                n_col  = '0;
                if (glyph_mask == '0) begin
                    n_cursor = r_cursor + CURSOR_W'(GLYPH_ADVANCE);
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // An unlit cell moves on at once; a lit one waits for room.
                if (!cell_lit || out_free) begin
                    n_mask = mask_left;
                    if (cell_lit) begin
                        n_out.pixel_address = r_base + {{(ADDR_W-CURSOR_W){1'b0}}, cur_px};
                        n_out.pixel_x       = cur_px[COORD_W-1:0];
                        n_out.pixel_y       = cur_py[COORD_W-1:0];
                        n_out.pixel_color   = r_ink;
                        n_out.last_write    = (mask_left == '0);
                        n_out_valid         = 1'b1;
                    end
                    n_pos = r_pos + 1'b1;
                    if (r_col == ROW_W'(GLYPH_COLS - 1)) begin
                        n_col  = '0;
                        n_row  = r_row + 1'b1;
                        n_base = r_base + {{(ADDR_W-WIDTH_W){1'b0}}, r_width};
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                    if (mask_left == '0) begin
                        n_cursor = r_cursor + CURSOR_W'(GLYPH_ADVANCE);
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_scan_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_mask != '0))
        else $error("scan running with no lit cells left");

    a_scan_in_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_pos < CELL_IDX_W'(GLYPH_CELLS)))
        else $error("scan position beyond glyph");

    a_cursor_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && n_state == ST_IDLE)
        |=> (r_cursor == $past(r_cursor) + CURSOR_W'(GLYPH_ADVANCE)))
        else $error("cursor did not advance by one glyph");

    a_pixel_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (({1'b0, r_out.pixel_x} < r_width)
                         && (r_out.pixel_y < r_height)))
        else $error("pixel request outside the frame");
`endif

endmodule
